>>> hdl/csrr_pkg.sv
// Shared constants and the knob scaling function for the crossfaded sample-rate reducer.
// Used by the top level and by the divide-by-4095 pipeline; no dependencies.
`timescale 1ns / 1ps

package csrr_pkg;

    localparam int BLOCK_SIZE_DEFAULT = 24;
    localparam int KNOB_W             = 12;
    localparam int SAMPLE_W           = 16;
    localparam int KNOB_FULL          = 4095;
    localparam int KNOB_STEPS         = 6;
    localparam int MAX_EXP            = 6;
    localparam int EXP_W              = 3;
    localparam int SCALED_W           = 15;
    localparam int NUM_W              = 30;
    localparam int MAG_W              = 27;

    function automatic logic [EXP_W-1:0] step_of(input logic [SCALED_W-1:0] scaled);
        logic [EXP_W-1:0] k;
        k = '0;
        for (int j = 1; j <= KNOB_STEPS; j++)
        begin
            if (scaled >= SCALED_W'(j * KNOB_FULL))
            begin
                k = EXP_W'(j);
            end
        end
        return k;
    endfunction

endpackage

>>> hdl/csrr_div4095.sv
// Two-stage pipeline that divides a signed numerator by 4095, truncating toward zero.
// Depends on csrr_pkg for the numerator width and the divisor.
`timescale 1ns / 1ps

module csrr_div4095
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   num_valid,
    output logic                                   num_stall,
    input  logic signed [csrr_pkg::NUM_W-1:0]      num,
    output logic                                   quo_valid,
    input  logic                                   quo_stall,
    output logic signed [csrr_pkg::SAMPLE_W-1:0]   quo
);

    localparam int PROD_W = csrr_pkg::MAG_W + 13;
    localparam int Q_W    = csrr_pkg::SAMPLE_W;
    localparam int R_W    = csrr_pkg::MAG_W + 1;

    logic                           a_vld_reg;
    logic                           a_neg_reg;
    logic [csrr_pkg::MAG_W-1:0]     a_mag_reg;
    logic [Q_W-1:0]                 a_q0_reg;
    logic                           b_vld_reg;
    logic signed [Q_W-1:0]          b_quo_reg;

    logic                           b_rdy;
    logic                           a_rdy;
    logic [csrr_pkg::NUM_W-1:0]     mag_full;
    logic [PROD_W-1:0]              prod;
    logic [R_W-1:0]                 rem;
    logic [Q_W:0]                   q_fix;
    logic [Q_W:0]                   q_signed;

    assign b_rdy     = !b_vld_reg || !quo_stall;
    assign a_rdy     = !a_vld_reg || b_rdy;
    assign num_stall = !a_rdy;

    // The quotient estimate uses 4097 / 2^24, which is at most one below the true quotient.
    always_comb
    begin
        mag_full = num[csrr_pkg::NUM_W-1] ? (~num + csrr_pkg::NUM_W'(1)) : num;
        prod     = PROD_W'(mag_full[csrr_pkg::MAG_W-1:0])
                 + (PROD_W'(mag_full[csrr_pkg::MAG_W-1:0]) << 12);
        rem      = R_W'(a_mag_reg) - ((R_W'(a_q0_reg) << 12) - R_W'(a_q0_reg));
        q_fix    = (Q_W+1)'(a_q0_reg)
                 + (Q_W+1)'(rem >= R_W'(csrr_pkg::KNOB_FULL));
        q_signed = a_neg_reg ? (~q_fix + (Q_W+1)'(1)) : q_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_vld_reg <= num_valid;
            end
            if (b_rdy)
            begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && num_valid)
        begin
            a_neg_reg <= num[csrr_pkg::NUM_W-1];
            a_mag_reg <= mag_full[csrr_pkg::MAG_W-1:0];
            a_q0_reg  <= prod[PROD_W-1 -: Q_W];
        end
        if (b_rdy && a_vld_reg)
        begin
            b_quo_reg <= $signed(q_signed[Q_W-1:0]);
        end
    end

    assign quo_valid = b_vld_reg;
    assign quo       = b_quo_reg;

endmodule

>>> hdl/crossfaded_sample_rate_reducer.sv
// Top level of the crossfaded sample-rate reducer: block counter, hold registers, crossfade.
// Depends on csrr_pkg and instantiates csrr_div4095.
`timescale 1ns / 1ps

// The block accepts one sample beat per clock while feed_stall is low and presents one result
// beat per sample through a five-register pipeline: input register, hold update, crossfade
// multiply, and two divide-by-4095 stages. The knob value is latched at the first sample of
// every block of BLOCK_SIZE samples and ignored otherwise. A stall on the result side fills
// the pipeline before the feed side is stalled.

module crossfaded_sample_rate_reducer
#(
    parameter int BLOCK_SIZE = csrr_pkg::BLOCK_SIZE_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   feed_valid,
    output logic                                   feed_stall,
    input  logic signed [csrr_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic [csrr_pkg::KNOB_W-1:0]            control_value,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [csrr_pkg::SAMPLE_W-1:0]   sample_out
);

    localparam int POS_W  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int EXP_W  = csrr_pkg::EXP_W;
    localparam int SW     = csrr_pkg::SAMPLE_W;
    localparam int NUM_W  = csrr_pkg::NUM_W;

    logic                           s0_vld_reg;
    logic signed [SW-1:0]           s0_sample_reg;
    logic [csrr_pkg::KNOB_W-1:0]    s0_knob_reg;

    logic [POS_W-1:0]               pos_reg;
    logic [EXP_W-1:0]               k_reg;
    logic [csrr_pkg::KNOB_W-1:0]    frac_reg;
    logic signed [SW-1:0]           fine_reg;
    logic signed [SW-1:0]           coarse_reg;

    logic                           s1_vld_reg;
    logic signed [SW-1:0]           s1_fine_reg;
    logic signed [SW:0]             s1_diff_reg;
    logic [csrr_pkg::KNOB_W-1:0]    s1_frac_reg;

    logic                           s2_vld_reg;
    logic signed [NUM_W-1:0]        s2_num_reg;

    logic                           div_stall;
    logic                           s2_rdy;
    logic                           s1_rdy;
    logic                           s0_rdy;

    logic [csrr_pkg::SCALED_W-1:0]  scaled;
    logic [EXP_W-1:0]               k_new;
    logic [csrr_pkg::SCALED_W-1:0]  frac_wide;
    logic [csrr_pkg::KNOB_W-1:0]    frac_new;
    logic [EXP_W-1:0]               cexp;
    logic [POS_W-1:0]               fine_mask;
    logic [POS_W-1:0]               coarse_mask;
    logic signed [SW-1:0]           fine_new;
    logic signed [SW-1:0]           coarse_new;
    logic [POS_W-1:0]               pos_next;
    logic signed [NUM_W-1:0]        fine_ext;
    logic signed [NUM_W-1:0]        cross_prod;
    logic signed [NUM_W-1:0]        num_next;

    assign s2_rdy     = !s2_vld_reg || !div_stall;
    assign s1_rdy     = !s1_vld_reg || s2_rdy;
    assign s0_rdy     = !s0_vld_reg || s1_rdy;
    assign feed_stall = !s0_rdy;

    always_comb
    begin
        scaled    = (csrr_pkg::SCALED_W'(s0_knob_reg) << 2)
                  + (csrr_pkg::SCALED_W'(s0_knob_reg) << 1);
        k_new     = (pos_reg == '0) ? csrr_pkg::step_of(scaled) : k_reg;
        frac_wide = scaled - csrr_pkg::SCALED_W'(k_new) * csrr_pkg::SCALED_W'(csrr_pkg::KNOB_FULL);
        frac_new  = (pos_reg == '0) ? frac_wide[csrr_pkg::KNOB_W-1:0] : frac_reg;
        cexp      = (k_new >= EXP_W'(csrr_pkg::MAX_EXP)) ? EXP_W'(csrr_pkg::MAX_EXP)
                                                         : k_new + EXP_W'(1);
        fine_mask   = POS_W'((8'd1 << k_new) - 8'd1);
        coarse_mask = POS_W'((8'd1 << cexp) - 8'd1);
        fine_new    = ((pos_reg & fine_mask) == '0) ? s0_sample_reg : fine_reg;
        coarse_new  = ((pos_reg & coarse_mask) == '0) ? s0_sample_reg : coarse_reg;
        pos_next    = (pos_reg == POS_W'(BLOCK_SIZE - 1)) ? '0 : pos_reg + POS_W'(1);
    end

    always_comb
    begin
        fine_ext   = NUM_W'(s1_fine_reg);
        cross_prod = NUM_W'(s1_diff_reg) * NUM_W'($signed({1'b0, s1_frac_reg}));
        num_next   = (fine_ext <<< 12) - fine_ext + cross_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            pos_reg    <= '0;
            k_reg      <= '0;
            frac_reg   <= '0;
            fine_reg   <= '0;
            coarse_reg <= '0;
        end
        else
        begin
            if (s0_rdy)
            begin
                s0_vld_reg <= feed_valid;
            end
            if (s1_rdy)
            begin
                s1_vld_reg <= s0_vld_reg;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s1_rdy && s0_vld_reg)
            begin
                pos_reg    <= pos_next;
                k_reg      <= k_new;
                frac_reg   <= frac_new;
                fine_reg   <= fine_new;
                coarse_reg <= coarse_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_rdy && feed_valid)
        begin
            s0_sample_reg <= sample_in;
            s0_knob_reg   <= control_value;
        end
        if (s1_rdy && s0_vld_reg)
        begin
            s1_fine_reg <= fine_new;
            s1_diff_reg <= (SW+1)'(coarse_new) - (SW+1)'(fine_new);
            s1_frac_reg <= frac_new;
        end
        if (s2_rdy && s1_vld_reg)
        begin
            s2_num_reg <= num_next;
        end
    end

    csrr_div4095 u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (s2_vld_reg),
        .num_stall (div_stall),
        .num       (s2_num_reg),
        .quo_valid (result_valid),
        .quo_stall (result_stall),
        .quo       (sample_out)
    );

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < BLOCK_SIZE)
        else $error("block position out of range");

    a_top_step_no_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg == EXP_W'(csrr_pkg::MAX_EXP)) |-> (frac_reg == '0))
        else $error("fraction not zero at the top step");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg <= EXP_W'(csrr_pkg::MAX_EXP)) && (frac_reg < 12'(csrr_pkg::KNOB_FULL)))
        else $error("latched step or fraction out of range");

    a_block_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_rdy && s0_vld_reg && pos_reg == '0) |=> (fine_reg == coarse_reg))
        else $error("holds differ after the first sample of a block");

endmodule
